>>> rtl/mtc_pkg.sv
// Package for the monomial transform coefficient block.
// Holds the command, result and matrix types, register codes and the binomial table.
// Used by mtc_regs and monomial_transform_coeff_top; depends on nothing.
package mtc_pkg;

	localparam int SLOT_W     = 18;
	localparam int REG_W      = 3 * SLOT_W;
	localparam int ENTRY_FRAC = 16;
	localparam int EXP_W      = 4;
	localparam int DATA_W     = 64;
	localparam int ADDR_W     = 5;
	localparam int COEF_W     = 32;
	localparam int BINOM_W    = 10;
	localparam int HARD_DEGREE = 12;

	localparam logic [1:0] REG_COL_X = 2'd0;
	localparam logic [1:0] REG_COL_Y = 2'd1;
	localparam logic [1:0] REG_COL_Z = 2'd2;

	localparam logic [REG_W-1:0] RESET_COL_X = 54'd65536;
	localparam logic [REG_W-1:0] RESET_COL_Y = 54'd17179869184;
	localparam logic [REG_W-1:0] RESET_COL_Z = 54'd4503599627370496;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_DEGREE = 2'd1;
	localparam logic [1:0] STAT_SAT    = 2'd2;

	typedef struct packed {
		logic [EXP_W-1:0] src_exp_x;
		logic [EXP_W-1:0] src_exp_y;
		logic [EXP_W-1:0] src_exp_z;
		logic [EXP_W-1:0] dst_exp_x;
		logic [EXP_W-1:0] dst_exp_y;
		logic [EXP_W-1:0] dst_exp_z;
	} cmd_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic [1:0]               status;
	} result_t;

	typedef struct packed {
		logic [REG_W-1:0] col_x;
		logic [REG_W-1:0] col_y;
		logic [REG_W-1:0] col_z;
	} matrix_t;

	// Binomial coefficients C(n, k) for n and k up to twelve, zero where k exceeds n.
	localparam logic [BINOM_W-1:0] BINOM_TAB [13][13] = '{
		'{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd2, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd3, 10'd3, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd4, 10'd6, 10'd4, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd5, 10'd10, 10'd10, 10'd5, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd6, 10'd15, 10'd20, 10'd15, 10'd6, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd7, 10'd21, 10'd35, 10'd35, 10'd21, 10'd7, 10'd1, 10'd0, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd8, 10'd28, 10'd56, 10'd70, 10'd56, 10'd28, 10'd8, 10'd1, 10'd0, 10'd0,
			10'd0, 10'd0},
		'{10'd1, 10'd9, 10'd36, 10'd84, 10'd126, 10'd126, 10'd84, 10'd36, 10'd9, 10'd1,
			10'd0, 10'd0, 10'd0},
		'{10'd1, 10'd10, 10'd45, 10'd120, 10'd210, 10'd252, 10'd210, 10'd120, 10'd45, 10'd10,
			10'd1, 10'd0, 10'd0},
		'{10'd1, 10'd11, 10'd55, 10'd165, 10'd330, 10'd462, 10'd462, 10'd330, 10'd165, 10'd55,
			10'd11, 10'd1, 10'd0},
		'{10'd1, 10'd12, 10'd66, 10'd220, 10'd495, 10'd792, 10'd924, 10'd792, 10'd495, 10'd220,
			10'd66, 10'd12, 10'd1}
	};

endpackage

>>> rtl/mtc_regs.sv
// Configuration register file for the monomial transform coefficient block.
// Holds the three matrix columns behind an APB-style port with 64-bit data.
// Depends on mtc_pkg.
module mtc_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mtc_pkg::ADDR_W-1:0] paddr,
	input  logic [mtc_pkg::DATA_W-1:0] pwdata,
	output logic [mtc_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output mtc_pkg::matrix_t          matrix
);
	import mtc_pkg::*;

	logic [REG_W-1:0] col_x_q;
	logic [REG_W-1:0] col_y_q;
	logic [REG_W-1:0] col_z_q;
	logic [1:0]       reg_idx;
	logic             wr_en;

	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_x_q <= RESET_COL_X;
			col_y_q <= RESET_COL_Y;
			col_z_q <= RESET_COL_Z;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_COL_X: col_x_q <= pwdata[REG_W-1:0];
				REG_COL_Y: col_y_q <= pwdata[REG_W-1:0];
				REG_COL_Z: col_z_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COL_X: prdata = DATA_W'(col_x_q);
			REG_COL_Y: prdata = DATA_W'(col_y_q);
			REG_COL_Z: prdata = DATA_W'(col_z_q);
			default:   prdata = '0;
		endcase
	end

	assign matrix.col_x = col_x_q;
	assign matrix.col_y = col_y_q;
	assign matrix.col_z = col_z_q;

endmodule

>>> rtl/monomial_transform_coeff_top.sv
// Top level of the monomial transform coefficient block.
// Holds the term sequencer, the shared multiplier and the accumulator.
// Depends on mtc_pkg and mtc_regs.

// A command transfer is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears on result for exactly one cycle with
// done high, and the receiver cannot stall it, so it must capture it in that cycle. Commands
// that exceed the degree limit, have mismatched degrees or have degree zero go straight to
// the done state. Otherwise every pair of split indices of the x and y exponents is visited:
// a pair that yields no valid term passes only through the term and next states, and a valid
// term is built by one multiplier doing every step in turn (one rounded product for each
// power of a matrix entry, then six exact products by binomial factors), each step being a
// multiply state followed by a write-back state, and is then accumulated. The convert,
// saturate and done states then convert, saturate and present the sum.
module monomial_transform_coeff_top #(
	parameter int MAX_DEGREE = 6,
	parameter int FRAC_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  mtc_pkg::cmd_t             cmd,
	output logic                      busy,
	output logic                      done,
	output mtc_pkg::result_t          result,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mtc_pkg::ADDR_W-1:0] paddr,
	input  logic [mtc_pkg::DATA_W-1:0] pwdata,
	output logic [mtc_pkg::DATA_W-1:0] prdata,
	output logic                      pready
);
	import mtc_pkg::*;

	localparam int DEG_LIMIT = (MAX_DEGREE < HARD_DEGREE) ? MAX_DEGREE : HARD_DEGREE;
	localparam int M_W       = ENTRY_FRAC + 1 + DEG_LIMIT + (DEG_LIMIT * 1585 + 999) / 1000;
	localparam int P_W       = M_W + SLOT_W;
	localparam int ACC_W     = M_W + 11;
	localparam int SH_UP     = (FRAC_BITS >= ENTRY_FRAC) ? FRAC_BITS - ENTRY_FRAC : 0;
	localparam int SH_DN     = (FRAC_BITS < ENTRY_FRAC) ? ENTRY_FRAC - FRAC_BITS : 1;
	localparam int CONV_W    = ACC_W + SH_UP;
	localparam int NUM_FACT  = 9;
	localparam int NUM_BIN   = 6;
	localparam int DEG_W     = 6;
	localparam int K_W       = 8;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_TERM = 11'b00000000010,
		ST_FACT = 11'b00000000100,
		ST_MULW = 11'b00000001000,
		ST_BINI = 11'b00000010000,
		ST_BINW = 11'b00000100000,
		ST_ACC  = 11'b00001000000,
		ST_NEXT = 11'b00010000000,
		ST_CONV = 11'b00100000000,
		ST_SATS = 11'b01000000000,
		ST_DONE = 11'b10000000000
	} state_t;

	matrix_t matrix;

	mtc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.matrix  (matrix)
	);

	state_t state_q;

	logic [EXP_W-1:0] lx_q, ly_q, lz_q, ax_q, ay_q, az_q;
	logic [EXP_W-1:0] i0_q, i1_q, j0_q, j1_q;
	logic [EXP_W-1:0] pow_q [NUM_FACT];
	logic [BINOM_W-1:0] binom_q [NUM_BIN];
	logic [3:0] f_q;
	logic [EXP_W-1:0] cnt_q;
	logic [2:0] b_q;
	logic [M_W-1:0] m_q;
	logic [P_W-1:0] p_q;
	logic sign_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CONV_W-1:0] conv_q;
	logic neg_q;
	logic signed [COEF_W-1:0] res_q;
	logic [1:0] stat_q;

	logic accept;
	logic [DEG_W-1:0] sd, td;
	logic deg_over;

	logic [SLOT_W-1:0] entry_mag [NUM_FACT];
	logic              entry_neg [NUM_FACT];
	logic [REG_W-1:0]  cols [3];

	logic [EXP_W-1:0] i2, j2, rx, ry;
	logic signed [K_W-1:0] k0, k1, k2, ksum;
	logic term_ok;
	logic [BINOM_W-1:0] binom_d [NUM_BIN];

	logic [SLOT_W-1:0] mul_b;
	logic [P_W-1:0]    product;
	logic [P_W-1:0]    rounded;

	logic [ACC_W-1:0]  mag;
	logic [ACC_W:0]    mag_rnd;
	logic [CONV_W-1:0] conv_d;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_DONE);
	assign result.coefficient = res_q;
	assign result.status      = stat_q;

	assign sd = DEG_W'(cmd.src_exp_x) + DEG_W'(cmd.src_exp_y) + DEG_W'(cmd.src_exp_z);
	assign td = DEG_W'(cmd.dst_exp_x) + DEG_W'(cmd.dst_exp_y) + DEG_W'(cmd.dst_exp_z);
	assign deg_over = (sd > DEG_W'(DEG_LIMIT)) || (td > DEG_W'(DEG_LIMIT));

	assign cols[0] = matrix.col_x;
	assign cols[1] = matrix.col_y;
	assign cols[2] = matrix.col_z;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				entry_neg[3*c+r] = cols[c][SLOT_W*r + SLOT_W - 1];
				entry_mag[3*c+r] = entry_neg[3*c+r] ?
					SLOT_W'({1'b1, {SLOT_W{1'b0}}} - {1'b0, cols[c][SLOT_W*r +: SLOT_W]}) :
					cols[c][SLOT_W*r +: SLOT_W];
			end
		end
	end

	assign i2 = lx_q - i0_q - i1_q;
	assign j2 = ly_q - j0_q - j1_q;
	assign rx = lx_q - i0_q;
	assign ry = ly_q - j0_q;
	assign k0 = K_W'(ax_q) - K_W'(i0_q) - K_W'(j0_q);
	assign k1 = K_W'(ay_q) - K_W'(i1_q) - K_W'(j1_q);
	assign k2 = K_W'(az_q) - K_W'(i2) - K_W'(j2);
	assign ksum = k0 + k1 + k2;
	assign term_ok = !k0[K_W-1] && !k1[K_W-1] && !k2[K_W-1] && (ksum == K_W'(lz_q));

	assign binom_d[0] = BINOM_TAB[lx_q][i0_q];
	assign binom_d[1] = BINOM_TAB[rx][i1_q];
	assign binom_d[2] = BINOM_TAB[ly_q][j0_q];
	assign binom_d[3] = BINOM_TAB[ry][j1_q];
	assign binom_d[4] = BINOM_TAB[lz_q][k0[EXP_W-1:0]];
	assign binom_d[5] = BINOM_TAB[lz_q - k0[EXP_W-1:0]][k1[EXP_W-1:0]];

	always_comb begin
		if (state_q == ST_FACT) begin
			mul_b = entry_mag[f_q];
		end else begin
			mul_b = SLOT_W'(binom_q[b_q]);
		end
	end

	assign product = P_W'(m_q) * P_W'(mul_b);
	assign rounded = p_q + (P_W'(1) << (ENTRY_FRAC - 1));

	assign mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign mag_rnd = ({1'b0, mag} + ((ACC_W+1)'(1) << (SH_DN - 1))) >> SH_DN;

	always_comb begin
		if (FRAC_BITS >= ENTRY_FRAC) begin
			conv_d = CONV_W'(mag) << SH_UP;
		end else begin
			conv_d = CONV_W'(mag_rnd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (deg_over || (sd != td) || (sd == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_TERM;
						end
					end
				end
				ST_TERM: state_q <= term_ok ? ST_FACT : ST_NEXT;
				ST_FACT: begin
					if (f_q == 4'(NUM_FACT)) begin
						state_q <= ST_BINI;
					end else if (cnt_q != pow_q[f_q]) begin
						state_q <= ST_MULW;
					end
				end
				ST_MULW: state_q <= ST_FACT;
				ST_BINI: state_q <= (b_q == 3'(NUM_BIN)) ? ST_ACC : ST_BINW;
				ST_BINW: state_q <= ST_BINI;
				ST_ACC:  state_q <= ST_NEXT;
				ST_NEXT: begin
					if ((j1_q == ry) && (j0_q == ly_q) && (i1_q == rx) && (i0_q == lx_q)) begin
						state_q <= ST_CONV;
					end else begin
						state_q <= ST_TERM;
					end
				end
				ST_CONV: state_q <= ST_SATS;
				ST_SATS: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					lx_q <= cmd.src_exp_x;
					ly_q <= cmd.src_exp_y;
					lz_q <= cmd.src_exp_z;
					ax_q <= cmd.dst_exp_x;
					ay_q <= cmd.dst_exp_y;
					az_q <= cmd.dst_exp_z;
					i0_q <= '0;
					i1_q <= '0;
					j0_q <= '0;
					j1_q <= '0;
					acc_q <= '0;
					if (deg_over) begin
						res_q  <= '0;
						stat_q <= STAT_DEGREE;
					end else if ((sd == td) && (sd == '0)) begin
						res_q  <= COEF_W'(64'd1 << FRAC_BITS);
						stat_q <= STAT_OK;
					end else begin
						res_q  <= '0;
						stat_q <= STAT_OK;
					end
				end
			end
			ST_TERM: begin
				pow_q[0] <= i0_q;
				pow_q[1] <= i1_q;
				pow_q[2] <= i2;
				pow_q[3] <= j0_q;
				pow_q[4] <= j1_q;
				pow_q[5] <= j2;
				pow_q[6] <= k0[EXP_W-1:0];
				pow_q[7] <= k1[EXP_W-1:0];
				pow_q[8] <= k2[EXP_W-1:0];
				if (term_ok) begin
					for (int b = 0; b < NUM_BIN; b++) begin
						binom_q[b] <= binom_d[b];
					end
				end
				m_q    <= M_W'(1) << ENTRY_FRAC;
				sign_q <= 1'b0;
				f_q    <= '0;
				cnt_q  <= '0;
				b_q    <= '0;
			end
			ST_FACT: begin
				if (f_q != 4'(NUM_FACT)) begin
					if (cnt_q == pow_q[f_q]) begin
						f_q   <= f_q + 4'd1;
						cnt_q <= '0;
					end else begin
						p_q    <= product;
						sign_q <= sign_q ^ entry_neg[f_q];
						cnt_q  <= cnt_q + 1'b1;
					end
				end
			end
			ST_MULW: m_q <= rounded[ENTRY_FRAC +: M_W];
			ST_BINI: begin
				if (b_q != 3'(NUM_BIN)) begin
					p_q <= product;
					b_q <= b_q + 3'd1;
				end
			end
			ST_BINW: m_q <= p_q[M_W-1:0];
			ST_ACC: begin
				if (sign_q) begin
					acc_q <= acc_q - $signed(ACC_W'(m_q));
				end else begin
					acc_q <= acc_q + $signed(ACC_W'(m_q));
				end
			end
			ST_NEXT: begin
				priority if (j1_q != ry) begin
					j1_q <= j1_q + 1'b1;
				end else if (j0_q != ly_q) begin
					j0_q <= j0_q + 1'b1;
					j1_q <= '0;
				end else if (i1_q != rx) begin
					i1_q <= i1_q + 1'b1;
					j0_q <= '0;
					j1_q <= '0;
				end else if (i0_q != lx_q) begin
					i0_q <= i0_q + 1'b1;
					i1_q <= '0;
					j0_q <= '0;
					j1_q <= '0;
				end
			end
			ST_CONV: begin
				conv_q <= conv_d;
				neg_q  <= acc_q[ACC_W-1];
			end
			ST_SATS: begin
				if (!neg_q && (conv_q > CONV_W'(32'h7FFF_FFFF))) begin
					res_q  <= 32'sh7FFF_FFFF;
					stat_q <= STAT_SAT;
				end else if (neg_q && (conv_q > CONV_W'(33'h1_0000_0000 >> 1))) begin
					res_q  <= 32'sh8000_0000;
					stat_q <= STAT_SAT;
				end else if (neg_q) begin
					res_q <= -$signed(conv_q[COEF_W-1:0]);
				end else begin
					res_q <= $signed(conv_q[COEF_W-1:0]);
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

endmodule
